>>> rtl/fqdo_pkg.sv
// Shared constants, types and helpers for the frame queue with drop-oldest overflow.
// No dependencies. Used by the channel interfaces and the top level.
`default_nettype none

package fqdo_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int KEEP_W      = 3;
   localparam int CMP_W       = (FILL_W > KEEP_W) ? FILL_W : KEEP_W;
   localparam int ADV_W       = FILL_W + 1;

   localparam int ID_W        = 8;
   localparam int TIME_W      = 32;
   localparam int CNT_W       = 32;
   localparam int DEPTH_OUT_W = 3;
   localparam int TGT_W       = 2;
   localparam int TMO_W       = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [TGT_W-1:0] TARGET_DEPTH_RST   = TGT_W'(1);
   localparam logic [TMO_W-1:0] SIGNAL_TIMEOUT_RST = TMO_W'(500);

   typedef enum logic [0:0] {
      ACT_PUSH    = 1'b0,
      ACT_ACQUIRE = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_DEPTH   = 1'b0,
      CSR_SIGNAL_TIMEOUT = 1'b1
   } csr_index_type;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [FILL_W-1:0] fill_type;

   // ring pointer advance, modulo the queue depth (n never exceeds the depth)
   function automatic ptr_type ptr_adv(ptr_type p, fill_type n);
      logic [ADV_W-1:0] s;
      s = ADV_W'(p) + ADV_W'(n);
      if (s >= ADV_W'(QUEUE_DEPTH)) begin
         s = s - ADV_W'(QUEUE_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/fqdo_req_if.sv
// Request channel: valid/ready handshake carrying one push or acquire item.
// Depends on fqdo_pkg.
`default_nettype none

interface fqdo_req_if;
   import fqdo_pkg::*;

   logic                valid;
   logic                ready;
   action_type          action;
   logic [ID_W-1:0]     frame_id;
   logic [TIME_W-1:0]   time_ms;

   modport source (output valid, output action, output frame_id, output time_ms,
                   input ready);
   modport sink   (input valid, input action, input frame_id, input time_ms,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/fqdo_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item with statistics.
// Depends on fqdo_pkg.
`default_nettype none

interface fqdo_rsp_if;
   import fqdo_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [ID_W-1:0]        frame_out;
   logic [CNT_W-1:0]       produced_count;
   logic [CNT_W-1:0]       dropped_count;
   logic [CNT_W-1:0]       taken_count;
   logic [CNT_W-1:0]       reused_count;
   logic [DEPTH_OUT_W-1:0] depth_now;
   logic [DEPTH_OUT_W-1:0] depth_peak;
   logic [CNT_W-1:0]       depth_total;
   logic [CNT_W-1:0]       depth_samples;

   modport source (output valid, output ok, output frame_out, output produced_count,
                   output dropped_count, output taken_count, output reused_count,
                   output depth_now, output depth_peak, output depth_total,
                   output depth_samples, input ready);
   modport sink   (input valid, input ok, input frame_out, input produced_count,
                   input dropped_count, input taken_count, input reused_count,
                   input depth_now, input depth_peak, input depth_total,
                   input depth_samples, output ready);
endinterface

`default_nettype wire

>>> rtl/frame_queue_drop_oldest.sv
// Frame queue with drop-oldest overflow, drain-on-acquire and depth statistics.
// Depends on fqdo_pkg, fqdo_req_if and fqdo_rsp_if.
//
//   channel   direction   carries
//   req_if    in          action, frame_id, time_ms
//   rsp_if    out         ok, frame_out, counters, depth statistics
//   csr_*     in          target_depth, signal_timeout writes
//
// Registered path: input register, then ring update into the result register.
// One item per cycle sustained while rsp is ready; the ring, pointers and counters update in one pass.
// Synchronous active-high reset clears control state and counters; ring slots are
// not reset. A stalled rsp holds the result and the input register, backing up req.
`default_nettype none

module frame_queue_drop_oldest (
   input  wire                               clock,
   input  wire                               reset,
   fqdo_req_if.sink                          req_if,
   fqdo_rsp_if.source                        rsp_if,
   input  wire                               csr_we,
   input  wire [fqdo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [fqdo_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fqdo_pkg::*;

   // configuration
   logic [TGT_W-1:0]  target_ff;
   logic [TMO_W-1:0]  timeout_ff;

   // input register
   logic              in_valid_ff;
   action_type        in_action_ff;
   logic [ID_W-1:0]   in_id_ff;
   logic [TIME_W-1:0] in_time_ff;

   // queue state
   logic [ID_W-1:0]   slot_ff [QUEUE_DEPTH];
   ptr_type           head_ff, head_in;
   fill_type          fill_ff, fill_in;
   logic [ID_W-1:0]   cur_frame_ff, cur_frame_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic              seen_ff, seen_in;
   logic [CNT_W-1:0]  produced_ff, produced_in;
   logic [CNT_W-1:0]  dropped_ff, dropped_in;
   logic [CNT_W-1:0]  taken_ff, taken_in;
   logic [CNT_W-1:0]  reused_ff, reused_in;
   fill_type          peak_ff, peak_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  samples_ff, samples_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [ID_W-1:0]   rsp_frame_ff, rsp_frame_in;

   logic              process;
   logic              slot_we;
   ptr_type           slot_addr;
   logic              has_signal;
   logic [TIME_W-1:0] age;
   logic [CMP_W-1:0]  fill_ext, keep_ext;
   fill_type          drop_n, fill1;
   ptr_type           head1;

   assign process    = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || process;

   assign age        = in_time_ff - last_time_ff;
   assign has_signal = seen_ff && (age < TIME_W'(timeout_ff));

   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      cur_frame_in = cur_frame_ff;
      cur_valid_in = cur_valid_ff;
      last_time_in = last_time_ff;
      seen_in      = seen_ff;
      produced_in  = produced_ff;
      dropped_in   = dropped_ff;
      taken_in     = taken_ff;
      reused_in    = reused_ff;
      peak_in      = peak_ff;
      total_in     = total_ff;
      samples_in   = samples_ff;
      rsp_ok_in    = 1'b0;
      rsp_frame_in = '0;
      slot_we      = 1'b0;
      slot_addr    = ptr_adv(head_ff, fill_ff);
      fill_ext     = CMP_W'(fill_ff);
      keep_ext     = CMP_W'(target_ff) + CMP_W'(1);
      drop_n       = '0;
      fill1        = fill_ff;
      head1        = head_ff;

      if (fill_ext > keep_ext) begin
         drop_n = FILL_W'(fill_ext - keep_ext);
         fill1  = FILL_W'(keep_ext);
      end
      head1 = ptr_adv(head_ff, drop_n);

      if (process) begin
         unique case (in_action_ff)
            ACT_PUSH: begin
               slot_we = 1'b1;
               if (fill_ff >= FILL_W'(QUEUE_DEPTH)) begin
                  // full: overwrite the oldest slot
                  slot_addr  = head_ff;
                  head_in    = ptr_adv(head_ff, FILL_W'(1));
                  dropped_in = dropped_ff + CNT_W'(1);
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               produced_in  = produced_ff + CNT_W'(1);
               last_time_in = in_time_ff;
               seen_in      = 1'b1;
               rsp_ok_in    = 1'b1;
            end
            ACT_ACQUIRE: begin
               if (has_signal) begin
                  dropped_in = dropped_ff + CNT_W'(drop_n);
                  total_in   = total_ff + CNT_W'(fill1);
                  samples_in = samples_ff + CNT_W'(1);
                  if (fill1 > peak_ff) begin
                     peak_in = fill1;
                  end
                  if (fill1 != '0) begin
                     cur_frame_in = slot_ff[head1];
                     cur_valid_in = 1'b1;
                     head_in      = ptr_adv(head1, FILL_W'(1));
                     fill_in      = fill1 - FILL_W'(1);
                     taken_in     = taken_ff + CNT_W'(1);
                  end else begin
                     head_in   = head1;
                     fill_in   = fill1;
                     reused_in = reused_ff + CNT_W'(1);
                  end
                  rsp_ok_in = cur_valid_in;
                  if (cur_valid_in) begin
                     rsp_frame_in = cur_frame_in;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_DEPTH_RST;
         timeout_ff   <= SIGNAL_TIMEOUT_RST;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         cur_frame_ff <= '0;
         cur_valid_ff <= 1'b0;
         last_time_ff <= '0;
         seen_ff      <= 1'b0;
         produced_ff  <= '0;
         dropped_ff   <= '0;
         taken_ff     <= '0;
         reused_ff    <= '0;
         peak_ff      <= '0;
         total_ff     <= '0;
         samples_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_TARGET_DEPTH:   target_ff  <= csr_wdata[TGT_W-1:0];
               CSR_SIGNAL_TIMEOUT: timeout_ff <= csr_wdata[TMO_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         cur_frame_ff <= cur_frame_in;
         cur_valid_ff <= cur_valid_in;
         last_time_ff <= last_time_in;
         seen_ff      <= seen_in;
         produced_ff  <= produced_in;
         dropped_ff   <= dropped_in;
         taken_ff     <= taken_in;
         reused_ff    <= reused_in;
         peak_ff      <= peak_in;
         total_ff     <= total_in;
         samples_ff   <= samples_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_action_ff <= req_if.action;
         in_id_ff     <= req_if.frame_id;
         in_time_ff   <= req_if.time_ms;
      end
      if (slot_we) begin
         slot_ff[slot_addr] <= in_id_ff;
      end
      if (process) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_frame_ff <= rsp_frame_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.ok             = rsp_ok_ff;
   assign rsp_if.frame_out      = rsp_frame_ff;
   assign rsp_if.produced_count = produced_ff;
   assign rsp_if.dropped_count  = dropped_ff;
   assign rsp_if.taken_count    = taken_ff;
   assign rsp_if.reused_count   = reused_ff;
   assign rsp_if.depth_now      = DEPTH_OUT_W'(fill_ff);
   assign rsp_if.depth_peak     = DEPTH_OUT_W'(peak_ff);
   assign rsp_if.depth_total    = total_ff;
   assign rsp_if.depth_samples  = samples_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= FILL_W'(QUEUE_DEPTH)) && (peak_ff <= FILL_W'(QUEUE_DEPTH)))
      else $error("queue fill or peak above capacity");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (process && in_action_ff == ACT_PUSH) |=> produced_ff == $past(produced_ff) + CNT_W'(1))
      else $error("push did not bump the produced count");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !process) |=> in_valid_ff && $stable(in_time_ff))
      else $error("pending input item lost during stall");

   a_state_frozen: assert property (@(posedge clock) disable iff (reset)
      !process |=> $stable(fill_ff) && $stable(head_ff) && $stable(dropped_ff))
      else $error("queue state changed without an item");
`endif

endmodule

`default_nettype wire
